// ----- sv/chrg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package chrg_pkg;

    // hash round keys
    localparam logic [63:0] HASH_K0 = 64'h73ae2743a3eab13c;
    localparam logic [63:0] HASH_K1 = 64'h53a75d3f2123bda1;
    localparam logic [63:0] HASH_K2 = 64'h42a3bcba71a72843;

    localparam int unsigned SEED_W = 64;
    localparam int unsigned DRAW_W = 16;
    localparam int unsigned OPA_W  = 33;  // |hi - lo| needs 33 bits
    localparam int unsigned OPB_W  = 32;  // one half of the Q0.63 fraction
    localparam int unsigned PROD_W = OPA_W + OPB_W;

    // operation codes
    localparam logic [2:0] OP_USHORT  = 3'd0;
    localparam logic [2:0] OP_SSHORT  = 3'd1;
    localparam logic [2:0] OP_WORD    = 3'd2;
    localparam logic [2:0] OP_UNIFORM = 3'd3;
    localparam logic [2:0] OP_GAUSS   = 3'd4;

    // configuration register indexes
    localparam logic CFG_SEED   = 1'b0;
    localparam logic CFG_RESEED = 1'b1;

    typedef struct packed {
        logic              start;
        logic [SEED_W-1:0] seed;
    } t_hash_req;

    typedef struct packed {
        logic              done;
        logic [DRAW_W-1:0] value;
    } t_hash_rsp;

    typedef struct packed {
        logic [OPA_W-1:0] a;
        logic [OPB_W-1:0] b;
    } t_mul_req;

endpackage

`default_nettype wire

// ----- sv/counter_hash_random_generator.sv -----
// Reseed mode hashes twice per draw.
// ushort/short: 1 draw; word64: 4 draws; uniform: 4 draws;
// gaussian: 16 draws. The shared three-round hash unit sets the pace.
// One word at a time: a new word is taken the cycle after the result enters the output
// register, and a result waits to enter it while the result side stalls.
// Synchronous active-low reset: seed 0, reseed mode off, sequencer idle, no result.
`timescale 1ns / 1ps
`default_nettype none

module counter_hash_random_generator
    import chrg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // op[2:0], lo[34:3], hi[66:35], zero pad
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata   // value[63:0]
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_RANGE = 4'd2;
    localparam logic [3:0] S_DRAW  = 4'd3;
    localparam logic [3:0] S_H1    = 4'd4;
    localparam logic [3:0] S_H2    = 4'd5;
    localparam logic [3:0] S_MAG   = 4'd6;
    localparam logic [3:0] S_MUL1  = 4'd7;
    localparam logic [3:0] S_MUL2  = 4'd8;
    localparam logic [3:0] S_MUL3  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_AVG   = 4'd11;
    localparam logic [3:0] S_PUT   = 4'd12;

    // control
    logic [3:0]  r_state, n_state;
    logic [1:0]  r_dcnt, n_dcnt;
    logic [1:0]  r_ucnt, n_ucnt;
    logic        r_reseed, n_reseed;
    logic [63:0] r_seed, n_seed;
    logic        r_out_valid, n_out_valid;
    // payload
    logic [2:0]         r_op, n_op;
    logic signed [31:0] r_a, n_a;
    logic signed [31:0] r_b, n_b;
    logic signed [31:0] r_m, n_m;
    logic               r_sneg, n_sneg;
    logic [OPA_W-1:0]   r_as, n_as;
    logic [63:0]        r_w, n_w;
    logic [62:0]        r_mag, n_mag;
    logic [63:0]        r_pa, n_pa;
    logic [63:0]        r_mid, n_mid;
    logic signed [33:0] r_sum, n_sum;
    logic [63:0]        r_val, n_val;
    logic [63:0]        r_out, n_out;

    t_hash_req         hash_req;
    t_hash_rsp         hash_rsp;
    t_mul_req          mul_req;
    logic [PROD_W-1:0] mul_prod;

    // input fields
    logic [2:0]         in_op;
    logic signed [31:0] in_lo;
    logic signed [31:0] in_hi;

    // working values
    logic [63:0]        seed_inc;
    logic [63:0]        w_next;
    logic               draw_end;
    logic [15:0]        d_last;
    logic [15:0]        neg_d;
    logic [15:0]        ss_d;
    logic [31:0]        sig3;
    logic signed [32:0] s_diff;
    logic [63:0]        w_neg;
    logic [32:0]        ip;
    logic               frac;
    logic signed [34:0] base;
    logic signed [34:0] res_raw;
    logic signed [31:0] res;
    logic signed [33:0] sum_adj;

    function automatic logic [31:0] in_hi_reg_x3(input logic [31:0] h);
        return h + {h[30:0], 1'b0};
    endfunction

    assign in_op = s_axis_tdata[2:0];
    assign in_lo = s_axis_tdata[34:3];
    assign in_hi = s_axis_tdata[66:35];

    assign seed_inc = r_seed + 64'd1;
    assign w_next   = {r_w[47:0], hash_rsp.value};

    chrg_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (hash_req),
        .o_rsp   (hash_rsp)
    );

    chrg_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    // hash start: draw from the seed, then reseed from the incremented seed
    always_comb begin
        hash_req.start = 1'b0;
        hash_req.seed  = r_seed;
        if (r_state == S_DRAW) begin
            hash_req.start = 1'b1;
        end else if (r_state == S_H1 && hash_rsp.done && r_reseed) begin
            hash_req.start = 1'b1;
            hash_req.seed  = seed_inc;
        end
    end

    // multiplier operands: low then high half of the fraction
    always_comb begin
        mul_req.a = r_as;
        mul_req.b = (r_state == S_MUL1) ? r_mag[31:0] : {1'b0, r_mag[62:32]};
    end

    // signed short: even draws negated (draw still on the hash output without reseed)
    assign d_last = (r_state == S_H2) ? r_w[15:0] : hash_rsp.value;
    assign neg_d  = 16'd0 - d_last;
    assign ss_d   = d_last[0] ? d_last : neg_d;

    // range set-up
    assign sig3   = in_hi_reg_x3(r_b);
    assign s_diff = 33'(r_b) - 33'(r_a);
    assign w_neg  = 64'd0 - r_w;

    // scale and round toward zero, then saturate
    assign ip      = r_mid[63:31];
    assign frac    = (|r_mid[30:0]) || (|r_pa[31:0]);
    assign base    = r_sneg ? (35'(r_m) - $signed({2'b00, ip}))
                            : (35'(r_m) + $signed({2'b00, ip}));
    always_comb begin
        res_raw = base;
        if (!r_sneg && base < 0 && frac) begin
            res_raw = base + 35'sd1;
        end else if (r_sneg && base > 0 && frac) begin
            res_raw = base - 35'sd1;
        end
        if (res_raw > 35'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (res_raw < -35'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = res_raw[31:0];
        end
    end

    // mean of four, truncated toward zero
    assign sum_adj = r_sum + (r_sum[33] ? 34'sd3 : 34'sd0);

    // end of a draw: hash done with no reseed, or reseed hash done
    assign draw_end = (r_state == S_H1 && hash_rsp.done && !r_reseed)
                   || (r_state == S_H2 && hash_rsp.done);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_dcnt      = r_dcnt;
        n_ucnt      = r_ucnt;
        n_reseed    = r_reseed;
        n_seed      = r_seed;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_a         = r_a;
        n_b         = r_b;
        n_m         = r_m;
        n_sneg      = r_sneg;
        n_as        = r_as;
        n_w         = r_w;
        n_mag       = r_mag;
        n_pa        = r_pa;
        n_mid       = r_mid;
        n_sum       = r_sum;
        n_val       = r_val;
        n_out       = r_out;

        // configuration writes
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SEED:   n_seed   = i_cfg_data;
                CFG_RESEED: n_reseed = i_cfg_data[0];
                default:    n_reseed = r_reseed;
            endcase
        end

        // output register
        if (m_axis_tvalid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op   = in_op;
                    n_a    = in_lo;
                    n_b    = in_hi;
                    n_dcnt = 2'd0;
                    n_ucnt = 2'd0;
                    n_sum  = '0;
                    if (in_op inside {OP_USHORT, OP_SSHORT, OP_WORD}) begin
                        n_state = S_DRAW;
                    end else if (in_op inside {OP_UNIFORM, OP_GAUSS}) begin
                        n_state = S_PREP;
                    end else begin
                        n_val   = '0;
                        n_state = S_PUT;
                    end
                end
            end
            S_PREP: begin
                // gaussian: lo -/+ 3*sigma
                if (r_op == OP_GAUSS) begin
                    n_a = r_a - sig3;
                    n_b = r_a + sig3;
                end
                n_state = S_RANGE;
            end
            S_RANGE: begin
                n_m     = (r_b < r_a) ? r_b : r_a;
                n_sneg  = s_diff[32];
                n_as    = s_diff[32] ? OPA_W'(-s_diff) : OPA_W'(s_diff);
                n_state = S_DRAW;
            end
            S_DRAW: begin
                n_state = S_H1;
            end
            S_H1: begin
                if (hash_rsp.done) begin
                    n_w    = w_next;
                    n_seed = seed_inc;
                    if (r_reseed) begin
                        n_state = S_H2;
                    end
                end
            end
            S_H2: begin
                if (hash_rsp.done) begin
                    n_seed = r_seed + {48'd0, hash_rsp.value};
                end
            end
            S_MAG: begin
                n_mag   = r_w[63] ? (w_neg[63] ? {63{1'b1}} : w_neg[62:0]) : r_w[62:0];
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_pa    = mul_prod[63:0];
                n_state = S_MUL3;
            end
            S_MUL3: begin
                n_mid   = mul_prod[63:0] + {32'd0, r_pa[63:32]};
                n_state = S_FIN;
            end
            S_FIN: begin
                n_sum = r_sum + 34'(res);
                if (r_op == OP_UNIFORM) begin
                    n_val   = 64'(res);
                    n_state = S_PUT;
                end else if (r_ucnt == 2'd3) begin
                    n_state = S_AVG;
                end else begin
                    n_ucnt  = r_ucnt + 2'd1;
                    n_state = S_DRAW;
                end
            end
            S_AVG: begin
                n_val   = 64'(sum_adj >>> 2);
                n_state = S_PUT;
            end
            S_PUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out       = r_val;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // what follows a finished draw (uses the completed word)
        if (draw_end) begin
            if (r_op == OP_USHORT) begin
                n_val   = {48'd0, n_w[15:0]};
                n_state = S_PUT;
            end else if (r_op == OP_SSHORT) begin
                n_val   = 64'($signed(ss_d));
                n_state = S_PUT;
            end else if (r_dcnt != 2'd3) begin
                n_dcnt  = r_dcnt + 2'd1;
                n_state = S_DRAW;
            end else begin
                n_dcnt = 2'd0;
                if (r_op == OP_WORD) begin
                    n_val   = n_w;
                    n_state = S_PUT;
                end else begin
                    n_state = S_MAG;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_a    <= n_a;
        r_b    <= n_b;
        r_m    <= n_m;
        r_sneg <= n_sneg;
        r_as   <= n_as;
        r_w    <= n_w;
        r_mag  <= n_mag;
        r_pa   <= n_pa;
        r_mid  <= n_mid;
        r_sum  <= n_sum;
        r_val  <= n_val;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dcnt      <= 2'd0;
            r_ucnt      <= 2'd0;
            r_reseed    <= 1'b0;
            r_seed      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dcnt      <= n_dcnt;
            r_ucnt      <= n_ucnt;
            r_reseed    <= n_reseed;
            r_seed      <= n_seed;
            r_out_valid <= n_out_valid;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

`default_nettype wire

// ----- sv/chrg_hash.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Iterative hash: one round per cycle, three rounds per hash.
module chrg_hash
    import chrg_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_hash_req i_req,
    output t_hash_rsp      o_rsp
);

    logic [SEED_W-1:0] r_r, n_r;
    logic [1:0]        r_rnd, n_rnd;
    logic              r_busy, n_busy;
    logic              r_done, n_done;

    function automatic logic [SEED_W-1:0] round_key(input logic [1:0] idx);
        logic [SEED_W-1:0] k;
        case (idx)
            2'd0:    k = HASH_K0;
            2'd1:    k = HASH_K1;
            default: k = HASH_K2;
        endcase
        return k;
    endfunction

    // add key, times -7, xor key >> 7, xor self >>> 11
    function automatic logic [SEED_W-1:0] hash_round(input logic [SEED_W-1:0] r,
                                                    input logic [SEED_W-1:0] k);
        logic [SEED_W-1:0] x;
        logic [SEED_W-1:0] y;
        x = r + k;
        y = x - (x << 3);
        y = y ^ (k >> 7);
        y = y ^ SEED_W'($signed(y) >>> 11);
        return y;
    endfunction

    // round sequencer
    always_comb begin
        n_r    = r_r;
        n_rnd  = r_rnd;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_r    = i_req.seed;
            n_rnd  = 2'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_r = hash_round(r_r, round_key(r_rnd));
            if (r_rnd == 2'd2) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_rnd = r_rnd + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_r <= n_r;
        if (!i_rst_n) begin
            r_rnd  <= 2'd0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_rnd  <= n_rnd;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_r[DRAW_W-1:0];

endmodule

`default_nettype wire

// ----- sv/chrg_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Registered multiplier for the range scaling.
module chrg_mul
    import chrg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_mul_req    i_req,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- sv/chrg_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module chrg_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_cfg_we,
    input wire logic        i_cfg_idx,
    input wire logic [63:0] i_cfg_data,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [71:0] s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata
);

    // reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word present after reset");

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // a taken word drops ready in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready straight after accepting a word");

    // a result only ever follows work in progress
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind counter_hash_random_generator chrg_checker u_chrg_checker (.*);

`default_nettype wire

// ----- sim/counter_hash_random_generator_tb.sv -----
`timescale 1ns / 1ps

import chrg_pkg::*;

// Scoreboard: tracks its own seed and reseed setting, predicts each value on acceptance
class rng_scoreboard;
    logic [63:0] seed;
    bit          reseed;
    logic [63:0] expected_values[$];
    int          mismatches;

    function new();
        seed       = '0;
        reseed     = 1'b0;
        mismatches = 0;
    endfunction

    function logic [63:0] round_key(int i);
        case (i)
            0:       return 64'h73ae2743a3eab13c;
            1:       return 64'h53a75d3f2123bda1;
            default: return 64'h42a3bcba71a72843;
        endcase
    endfunction

    // three mixing rounds, low 16 bits kept
    function logic [15:0] hash16(logic [63:0] s);
        logic [63:0]        r;
        logic signed [63:0] rs;
        int                 i;
        r = s;
        for (i = 0; i < 3; i++) begin
            r  = r + round_key(i);
            r  = r - (r << 3);
            r  = r ^ (round_key(i) >> 7);
            rs = $signed(r) >>> 11;
            r  = r ^ rs;
        end
        return r[15:0];
    endfunction

    // one draw, then the counter steps (plus a rehash in reseed mode)
    function logic [15:0] draw();
        logic [15:0] d;
        d    = hash16(seed);
        seed = seed + 64'd1;
        if (reseed)
            seed = seed + {48'd0, hash16(seed)};
        return d;
    endfunction

    // first draw ends up in the top 16 bits
    function logic [63:0] draw_word();
        logic [63:0] w;
        int          i;
        w = '0;
        for (i = 0; i < 4; i++)
            w = {w[47:0], draw()};
        return w;
    endfunction

    // min(a,b) + (b-a) * |W|/2^63, truncated toward zero, saturated to 32 bits
    function longint pick_uniform(longint a, longint b);
        longint       s, m, ip, base, res;
        logic [63:0]  w, mag, span;
        logic [127:0] prod;
        bit           frac;
        s    = b - a;
        m    = (b < a) ? b : a;
        w    = draw_word();
        mag  = w[63] ? (64'd0 - w) : w;
        if (mag > 64'h7fff_ffff_ffff_ffff)
            mag = 64'h7fff_ffff_ffff_ffff;
        span = (s < 0) ? -s : s;
        prod = {64'd0, span} * {64'd0, mag};
        ip   = longint'(prod[126:63]);
        frac = |prod[62:0];
        if (s >= 0) begin
            base = m + ip;
            res  = (base < 0 && frac) ? base + 1 : base;
        end else begin
            base = m - ip;
            res  = (base > 0 && frac) ? base - 1 : base;
        end
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        return res;
    endfunction

    function logic [63:0] predict_value(logic [2:0] op, logic signed [31:0] lo,
                                        logic signed [31:0] hi);
        logic [15:0] d, t;
        logic [31:0] sig3, ta, tb;
        longint      a, b, sum;
        logic [63:0] v;
        int          i;
        v = '0;
        case (op)
            OP_USHORT:  v = {48'd0, draw()};
            OP_SSHORT: begin
                d = draw();
                t = d[0] ? d : 16'd0 - d;
                v = {{48{t[15]}}, t};
            end
            OP_WORD:    v = draw_word();
            OP_UNIFORM: v = pick_uniform(longint'(lo), longint'(hi));
            OP_GAUSS: begin
                // bounds are lo -/+ 3*sigma, wrapped to 32 bits
                sig3 = hi * 32'd3;
                ta   = lo - sig3;
                tb   = lo + sig3;
                a    = longint'($signed(ta));
                b    = longint'($signed(tb));
                sum  = 0;
                for (i = 0; i < 4; i++)
                    sum = sum + pick_uniform(a, b);
                v = sum / 4;
            end
            default:    v = '0;  // spare codes: no draw
        endcase
        return v;
    endfunction

    function void note_word(logic [2:0] op, logic signed [31:0] lo, logic signed [31:0] hi);
        expected_values.push_back(predict_value(op, lo, hi));
    endfunction

    function void check_value(logic [63:0] actual);
        logic [63:0] exp_value;
        if (expected_values.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected value %h with nothing pending", actual);
        end else begin
            exp_value = expected_values.pop_front();
            if (exp_value !== actual) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("value mismatch: expected %h, got %h", exp_value, actual);
            end
        end
    endfunction
endclass

module counter_hash_random_generator_tb;

    localparam int CYCLE_LIMIT       = 2_000_000;
    localparam int ITEMS_PER_SEGMENT = 142;
    localparam int DRAIN_CYCLES      = 200;

    // op codes with no function
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_idx     = 1'b0;
    logic [63:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;  // op[2:0], lo[34:3], hi[66:35], zero pad
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [63:0] m_axis_tdata;        // value[63:0]

    rng_scoreboard sb;
    int            tx_idle_pct = 13;
    int            rx_idle_pct = 56;
    int            cycles      = 0;
    int            seg;

    counter_hash_random_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result side: check accepted words, random back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_value(m_axis_tdata);
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // both registers, written back to back while idle
    task automatic configure(input logic [63:0] seed_value, input logic mode);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SEED;
        i_cfg_data <= seed_value;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RESEED;
        i_cfg_data <= {63'd0, mode};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.seed   = seed_value;
        sb.reseed = mode;
    endtask

    // tvalid stays high after acceptance unless a gap follows
    task automatic send_word(input logic [2:0] op, input logic signed [31:0] lo,
                             input logic signed [31:0] hi);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, hi, lo, op};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_word(op, lo, hi);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_values.size() != 0)
            @(posedge i_clk);
    endtask

    // mix of full-range, small, extreme and shifted values
    function automatic logic signed [31:0] pick_field();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 200)) - 32'sd100;
            2: begin
                case ($urandom_range(0, 3))
                    0:       return S32_MIN;
                    1:       return S32_MAX;
                    2:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return 32'($urandom_range(0, 65535)) << $urandom_range(0, 16);
        endcase
    endfunction

    task automatic send_random();
        logic [2:0]         op;
        logic signed [31:0] lo, hi;
        if ($urandom_range(0, 15) == 0)
            op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        else
            op = 3'($urandom_range(OP_USHORT, OP_GAUSS));
        lo = pick_field();
        if ($urandom_range(0, 3) == 0)
            hi = lo + 32'($urandom_range(0, 64)) - 32'sd32;
        else
            hi = pick_field();
        send_word(op, lo, hi);
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: seed zero, no reseed
        configure(64'd0, 1'b0);
        send_word(OP_USHORT, 32'sd0, 32'sd0);
        send_word(OP_SSHORT, 32'sd0, 32'sd0);
        send_word(OP_SSHORT, S32_MAX, S32_MIN);
        send_word(OP_WORD, -32'sd1, -32'sd1);
        send_word(OP_UNIFORM, S32_MIN, S32_MAX);
        send_word(OP_UNIFORM, S32_MAX, S32_MIN);       // reversed, full span
        send_word(OP_UNIFORM, 32'sd0, 32'sd0);
        send_word(OP_UNIFORM, S32_MAX, S32_MAX);
        send_word(OP_UNIFORM, -32'sd5, 32'sd5);
        send_word(OP_UNIFORM, 32'sd10, -32'sd10);      // reversed, small
        send_word(OP_GAUSS, 32'sd0, 32'sd0);
        send_word(OP_GAUSS, S32_MAX, S32_MAX);         // bounds wrap
        send_word(OP_GAUSS, S32_MIN, -32'sd1);
        send_word(OP_GAUSS, 32'sd100, 32'sd7);
        send_word(OP_SPARE_FIRST, -32'sd1, -32'sd1);
        send_word(3'd6, S32_MIN, S32_MAX);
        send_word(OP_SPARE_LAST, -32'sd1, -32'sd1);
        send_word(OP_USHORT, -32'sd1, -32'sd1);
        drain();

        // directed: counter about to wrap, reseed on
        configure(64'hffff_ffff_ffff_ffff, 1'b1);
        send_word(OP_SSHORT, 32'sd0, 32'sd0);
        send_word(OP_SSHORT, 32'sd0, 32'sd0);
        send_word(OP_WORD, 32'sd0, 32'sd0);
        send_word(OP_UNIFORM, S32_MIN, S32_MAX);
        send_word(OP_GAUSS, S32_MIN, S32_MAX);
        send_word(OP_USHORT, 32'sd0, 32'sd0);
        drain();

        // random: three idling phases, two settings each
        for (seg = 0; seg < 6; seg++) begin
            if (seg == 2) begin
                tx_idle_pct = 56;
                rx_idle_pct = 13;
            end else if (seg == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (seg)
                0:       configure(64'd0, 1'b0);
                1:       configure(64'hffff_ffff_ffff_ffff, 1'b1);
                4:       configure(64'h8000_0000_0000_0000, 1'b0);
                default: configure({$urandom, $urandom}, seg % 2 == 1);
            endcase
            repeat (ITEMS_PER_SEGMENT) send_random();
            drain();
        end

        // catch any stray words
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_values.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
